// ===== rtl/frame_store_page_transposer_defines.svh =====
// Assertion macros shared by the frame store page transposer.
`ifndef FRAME_STORE_PAGE_TRANSPOSER_DEFINES_SVH
`define FRAME_STORE_PAGE_TRANSPOSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every edge out of reset.
`define FSPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define FSPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSPT_ASSERT(label, prop, msg)
`define FSPT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/fspt_pkg.sv =====
// Types, constants and codes of the frame store page transposer.
package fspt_pkg;

    localparam int ROW_BYTES   = 16;
    localparam int FRAME_BYTES = 256;
    localparam int ROW_COUNT   = FRAME_BYTES / ROW_BYTES;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_MERGE = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_MERGE,
        OP_CLEAR,
        OP_READ,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              page;
        logic [3:0]        group;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic [7:0] vertical_byte;
        logic [6:0] column_index;
        logic       page_out;
        logic       status;
        logic       last;
    } res_t;

endpackage

// ===== rtl/fspt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fspt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fspt_front.sv =====
// Input side: unpacks an item, checks the write target and forms a command.
module fspt_front (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,
    input  logic [1:0]       s_tuser,
    input  fspt_pkg::q_stat_t q_stat,
    output logic             q_push,
    output fspt_pkg::cmd_t   cmd
);
    import fspt_pkg::*;

    logic [4:0] x_origin;
    logic [4:0] y_origin;
    logic [4:0] bmp_width;
    logic [4:0] bmp_height;
    logic [3:0] elem_col;
    logic [3:0] elem_row;
    logic [7:0] pixel_byte;
    logic       page_sel;
    logic [3:0] column_group;
    logic [5:0] col;
    logic [5:0] row;
    logic       place_ok;

    assign x_origin     = s_tdata[4:0];
    assign y_origin     = s_tdata[9:5];
    assign bmp_width    = s_tdata[14:10];
    assign bmp_height   = s_tdata[19:15];
    assign elem_col     = s_tdata[23:20];
    assign elem_row     = s_tdata[27:24];
    assign pixel_byte   = s_tdata[35:28];
    assign page_sel     = s_tdata[36];
    assign column_group = s_tdata[40:37];

    // A zero origin wraps here, but such an item is rejected anyway.
    assign col = {1'b0, x_origin} - 6'd1 + {2'b00, elem_col};
    assign row = {1'b0, y_origin} - 6'd1 + {2'b00, elem_row};

    assign place_ok = (x_origin != 5'd0) && (y_origin != 5'd0)
                   && ({1'b0, elem_col} < bmp_width) && ({1'b0, elem_row} < bmp_height)
                   && (int'(col) < ROW_BYTES) && (int'(row) < ROW_COUNT);

    always_comb
    begin
        cmd.addr  = ADDR_W'(int'(row) * ROW_BYTES + int'(col));
        cmd.data  = pixel_byte;
        cmd.page  = page_sel;
        cmd.group = column_group;
        case (func_t'(s_tuser))
            FUNC_WRITE: cmd.op = place_ok ? OP_WRITE : OP_REJECT;
            FUNC_MERGE: cmd.op = place_ok ? OP_MERGE : OP_REJECT;
            FUNC_CLEAR: cmd.op = OP_CLEAR;
            FUNC_READ:  cmd.op = OP_READ;
            default:    cmd.op = OP_REJECT;
        endcase
    end

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready;

endmodule

// ===== rtl/fspt_cmd_queue.sv =====
// Short command queue between the input side and the execution side.
module fspt_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fspt_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output fspt_pkg::cmd_t    head_cmd,
    output fspt_pkg::q_stat_t stat
);
    import fspt_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (int'(count_reg) == Q_DEPTH);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                if (int'(wr_ptr_reg) == Q_DEPTH - 1)
                begin
                    wr_ptr_reg <= '0;
                end
                else
                begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (do_pop)
            begin
                if (int'(rd_ptr_reg) == Q_DEPTH - 1)
                begin
                    rd_ptr_reg <= '0;
                end
                else
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/fspt_back.sv =====
// Execution side: frame store access, page transpose and the result register.
module fspt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  fspt_pkg::cmd_t    head_cmd,
    input  fspt_pkg::q_stat_t q_stat,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output fspt_pkg::res_t    res
);
    import fspt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MERGE_RD,
        S_SINGLE,
        S_RD,
        S_RD_WAIT,
        S_EMIT
    } state_t;

    state_t             state_reg;
    cmd_t               cur_reg;
    logic [2:0]         cnt_reg;
    logic               cap_en_reg;
    logic [2:0]         cap_idx_reg;
    logic               rd_ok_reg;
    logic [7:0]         rows_reg [8];
    logic [FRAME_BYTES-1:0] vld_reg;
    logic               m_tvalid_reg;
    res_t               res_reg;

    logic               out_free;
    logic               res_load;
    logic [3:0]         rd_row;
    logic               rd_ok;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_byte;
    logic [7:0]         col_bits;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    fspt_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && !q_stat.empty;

    // A new result enters the output register in these states only.
    assign res_load = out_free && ((state_reg == S_SINGLE) || (state_reg == S_EMIT));

    // Row of the page addressed in this read step.
    assign rd_row  = {cur_reg.page, cnt_reg};
    assign rd_ok   = (int'(rd_row) < ROW_COUNT) && (int'(cur_reg.group) < ROW_BYTES);
    assign rd_addr = ADDR_W'(int'(rd_row) * ROW_BYTES + int'(cur_reg.group));

    // Entries not written since the last clear read as zero.
    assign rd_byte = ram_rdata & {8{rd_ok_reg}};

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            col_bits[i] = rows_reg[i][cnt_reg];
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg.addr;
        ram_wdata = cur_reg.data;
        ram_re    = 1'b0;
        ram_raddr = cur_reg.addr;
        case (state_reg)
            S_MERGE_RD:
            begin
                ram_re = 1'b1;
            end
            S_RD:
            begin
                ram_re    = rd_ok;
                ram_raddr = rd_addr;
            end
            S_SINGLE:
            begin
                if (out_free && (cur_reg.op == OP_WRITE || cur_reg.op == OP_MERGE))
                begin
                    ram_we = 1'b1;
                end
                if (cur_reg.op == OP_MERGE)
                begin
                    ram_wdata = cur_reg.data | rd_byte;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cur_reg      <= '0;
            cnt_reg      <= '0;
            cap_en_reg   <= 1'b0;
            cap_idx_reg  <= '0;
            rd_ok_reg    <= 1'b0;
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            res_reg      <= '0;
            for (int i = 0; i < 8; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else
        begin
            if (res_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            cap_en_reg <= (state_reg == S_RD);
            if (cap_en_reg)
            begin
                rows_reg[cap_idx_reg] <= rd_byte;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        cur_reg <= head_cmd;
                        cnt_reg <= '0;
                        case (head_cmd.op)
                            OP_MERGE: state_reg <= S_MERGE_RD;
                            OP_READ:  state_reg <= S_RD;
                            default:  state_reg <= S_SINGLE;
                        endcase
                    end
                end
                S_MERGE_RD:
                begin
                    rd_ok_reg <= vld_reg[cur_reg.addr];
                    state_reg <= S_SINGLE;
                end
                S_SINGLE:
                begin
                    if (out_free)
                    begin
                        case (cur_reg.op)
                            OP_WRITE, OP_MERGE: vld_reg[cur_reg.addr] <= 1'b1;
                            OP_CLEAR:           vld_reg <= '0;
                            default:
                            begin
                            end
                        endcase
                        res_reg.vertical_byte <= '0;
                        res_reg.column_index  <= '0;
                        res_reg.page_out      <= 1'b0;
                        res_reg.status        <= (cur_reg.op == OP_REJECT);
                        res_reg.last          <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    rd_ok_reg   <= rd_ok && vld_reg[rd_addr];
                    cap_idx_reg <= cnt_reg;
                    cnt_reg     <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_reg <= S_RD_WAIT;
                    end
                end
                S_RD_WAIT:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        res_reg.vertical_byte <= col_bits;
                        res_reg.column_index  <= {cur_reg.group, cnt_reg};
                        res_reg.page_out      <= cur_reg.page;
                        res_reg.status        <= 1'b0;
                        res_reg.last          <= (cnt_reg == 3'd7);
                        cnt_reg               <= cnt_reg + 1'b1;
                        if (cnt_reg == 3'd7)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign res      = res_reg;

endmodule

// ===== rtl/frame_store_page_transposer.sv =====
// Top level of the frame store page transposer.
//
//  channel | direction | tdata                              | tuser | tlast
//  s_*     | in        | item fields, see port comment      | func  | -
//  m_*     | out       | result fields, see port comment    | -     | last
//
// A read item makes eight store reads through the single read port, waits
// in a wait state for the last read data, then makes eight result transfers.
// Write, clear and rejected items give one result each; a merge reads, then writes.
// The two-entry command queue takes items until it is full while the execution
// side works or the result register waits; a stalled m_tready holds the store side.
// Reset is asynchronous and active low; the store reads as zero after it,
// with no clearing pass, because each entry carries a valid flag.
`include "frame_store_page_transposer_defines.svh"

module frame_store_page_transposer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] x_origin, [9:5] y_origin, [14:10] bmp_width, [19:15] bmp_height,
    // [23:20] elem_col, [27:24] elem_row, [35:28] pixel_byte, [36] page_sel,
    // [40:37] column_group, [47:41] zero
    input  logic [47:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] vertical_byte, [14:8] column_index, [15] page_out, [16] status,
    // [23:17] zero
    output logic [23:0] m_tdata,
    output logic        m_tlast
);
    import fspt_pkg::*;

    cmd_t    push_cmd;
    cmd_t    head_cmd;
    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    res_t    res;

    fspt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .cmd      (push_cmd)
    );

    fspt_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    fspt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res      (res)
    );

    assign m_tdata = {7'b0, res.status, res.page_out, res.column_index, res.vertical_byte};
    assign m_tlast = res.last;

    `FSPT_ASSERT(a_no_push_when_full, q_push |-> !q_stat.full, "command pushed into a full queue")
    `FSPT_ASSERT(a_reject_is_last, m_tvalid && m_tdata[16] |-> m_tlast, "rejected item gave more than one result")
    `FSPT_ASSERT(a_pop_needs_entry, q_pop |-> !q_stat.empty, "command taken from an empty queue")
    `FSPT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "result offered during reset")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the frame store page transposer.
`timescale 1ns / 1ps

module tb_top;
    import fspt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 76;

    typedef struct {
        func_t      func;
        logic [4:0] x_origin;
        logic [4:0] y_origin;
        logic [4:0] bmp_width;
        logic [4:0] bmp_height;
        logic [3:0] elem_col;
        logic [3:0] elem_row;
        logic [7:0] pixel_byte;
        logic       page_sel;
        logic [3:0] column_group;
    } item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // Own copy of the frame store, updated as each item is accepted.
    logic [7:0] frame_copy [FRAME_BYTES];
    item_t      pending_items[$];
    res_t       expected_results[$];
    item_t      item_on_bus;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_served;
    int hold_left;
    int mismatch_count = 0;
    int quiet_cycles;

    frame_store_page_transposer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic item_t make_item(func_t f, int x, int y, int w, int h, int ec, int er,
                                        int px, int pg, int grp);
        item_t it;
        it.func         = f;
        it.x_origin     = 5'(x);
        it.y_origin     = 5'(y);
        it.bmp_width    = 5'(w);
        it.bmp_height   = 5'(h);
        it.elem_col     = 4'(ec);
        it.elem_row     = 4'(er);
        it.pixel_byte   = 8'(px);
        it.page_sel     = 1'(pg);
        it.column_group = 4'(grp);
        return it;
    endfunction

    // Works out the results of one item and applies it to the frame copy.
    function automatic void predict_frame_item(item_t it);
        int         col;
        int         row;
        logic       rejected;
        logic [7:0] vb;
        res_t       r;
        r = '0;
        r.last = 1'b1;
        case (it.func)
            FUNC_WRITE, FUNC_MERGE:
            begin
                rejected = 1'b1;
                if (it.x_origin != 0 && it.y_origin != 0 &&
                    it.elem_col < it.bmp_width && it.elem_row < it.bmp_height)
                begin
                    col = int'(it.x_origin) - 1 + int'(it.elem_col);
                    row = int'(it.y_origin) - 1 + int'(it.elem_row);
                    if (col < ROW_BYTES && row < ROW_COUNT)
                    begin
                        rejected = 1'b0;
                        if (it.func == FUNC_MERGE)
                            frame_copy[row * ROW_BYTES + col] |= it.pixel_byte;
                        else
                            frame_copy[row * ROW_BYTES + col] = it.pixel_byte;
                    end
                end
                r.status = rejected;
                expected_results.push_back(r);
            end
            FUNC_CLEAR:
            begin
                foreach (frame_copy[i])
                    frame_copy[i] = 8'h00;
                expected_results.push_back(r);
            end
            default:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    vb = 8'h00;
                    for (int i = 0; i < 8; i++)
                    begin
                        row = int'(it.page_sel) * 8 + i;
                        if (row < ROW_COUNT && it.column_group < ROW_BYTES)
                            vb[i] = frame_copy[row * ROW_BYTES + int'(it.column_group)][k];
                    end
                    r.vertical_byte = vb;
                    r.column_index  = 7'(int'(it.column_group) * 8 + k);
                    r.page_out      = it.page_sel;
                    r.status        = 1'b0;
                    r.last          = (k == 7);
                    expected_results.push_back(r);
                end
            end
        endcase
    endfunction

    // Mostly well-formed writes, merges and reads, with some full-range noise.
    function automatic item_t random_item();
        item_t it;
        int    pick;
        int    bw;
        int    bh;
        pick = $urandom_range(99);
        it = make_item(func_t'(2'($urandom_range(3))), $urandom_range(31), $urandom_range(31),
                       $urandom_range(31), $urandom_range(31), $urandom_range(15),
                       $urandom_range(15), $urandom_range(255), $urandom_range(1),
                       $urandom_range(15));
        if (pick < 12)
            return it;
        if (pick < 14)
        begin
            it.func = FUNC_CLEAR;
            return it;
        end
        if (pick < 44)
        begin
            it.func = FUNC_READ;
            return it;
        end
        it.func = (pick < 74) ? FUNC_WRITE : FUNC_MERGE;
        bw = $urandom_range(1, 16);
        bh = $urandom_range(1, 16);
        it.bmp_width  = 5'(bw);
        it.bmp_height = 5'(bh);
        it.elem_col   = 4'($urandom_range(bw - 1));
        it.elem_row   = 4'($urandom_range(bh - 1));
        if ($urandom_range(9) == 0)
        begin
            // Origin anywhere in the store, so the element may fall off its edge.
            it.x_origin = 5'($urandom_range(1, 16));
            it.y_origin = 5'($urandom_range(1, 16));
        end
        else
        begin
            it.x_origin = 5'($urandom_range(1, 17 - bw));
            it.y_origin = 5'($urandom_range(1, 17 - bh));
        end
        return it;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    task automatic wait_until_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Sender: offers queued items, inserting gaps at the current idle rate.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_frame_item(item_on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_on_bus = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= item_on_bus.func;
                    s_tdata  <= {7'd0, item_on_bus.column_group, item_on_bus.page_sel,
                                 item_on_bus.pixel_byte, item_on_bus.elem_row,
                                 item_on_bus.elem_col, item_on_bus.bmp_height,
                                 item_on_bus.bmp_width, item_on_bus.y_origin,
                                 item_on_bus.x_origin};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transfer and decides the next m_tready.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        res_t want;
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            hold_left   <= 0;
            hold_served <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", 0, int'(m_tdata));
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[7:0] != want.vertical_byte)
                        report_mismatch("vertical_byte", int'(want.vertical_byte),
                                        int'(m_tdata[7:0]));
                    if (m_tdata[14:8] != want.column_index)
                        report_mismatch("column_index", int'(want.column_index),
                                        int'(m_tdata[14:8]));
                    if (m_tdata[15] != want.page_out)
                        report_mismatch("page_out", int'(want.page_out), int'(m_tdata[15]));
                    if (m_tdata[16] != want.status)
                        report_mismatch("status", int'(want.status), int'(m_tdata[16]));
                    if (m_tlast != want.last)
                        report_mismatch("last", int'(want.last), int'(m_tlast));
                    if (m_tdata[23:17] != 7'd0)
                        report_mismatch("padding", 0, int'(m_tdata[23:17]));
                end
            end
            if (hold_served != hold_request)
            begin
                hold_served <= hold_request;
                hold_left   <= LONG_HOLD;
                m_tready    <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Ends the run when neither side has made a transfer for too long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        foreach (frame_copy[i])
            frame_copy[i] = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: corners, every rejection, page boundary and clear.
        pending_items.push_back(make_item(FUNC_READ,  1, 1, 1, 1, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_WRITE, 1, 1, 1, 1, 0, 0, 8'hff, 0, 0));
        pending_items.push_back(make_item(FUNC_WRITE, 16, 16, 1, 1, 0, 0, 8'h80, 1, 15));
        pending_items.push_back(make_item(FUNC_MERGE, 16, 16, 1, 1, 0, 0, 8'h01, 0, 0));
        pending_items.push_back(make_item(FUNC_WRITE, 0, 1, 1, 1, 0, 0, 8'h55, 0, 0));
        pending_items.push_back(make_item(FUNC_MERGE, 1, 0, 1, 1, 0, 0, 8'h55, 0, 0));
        pending_items.push_back(make_item(FUNC_WRITE, 1, 1, 2, 4, 2, 0, 8'haa, 0, 0));
        pending_items.push_back(make_item(FUNC_WRITE, 1, 1, 4, 2, 0, 2, 8'haa, 0, 0));
        pending_items.push_back(make_item(FUNC_WRITE, 1, 1, 0, 1, 0, 0, 8'haa, 0, 0));
        pending_items.push_back(make_item(FUNC_MERGE, 1, 1, 1, 0, 0, 0, 8'haa, 0, 0));
        pending_items.push_back(make_item(FUNC_WRITE, 16, 1, 16, 1, 1, 0, 8'h3c, 0, 0));
        pending_items.push_back(make_item(FUNC_WRITE, 1, 16, 1, 16, 0, 1, 8'h3c, 0, 0));
        pending_items.push_back(make_item(FUNC_WRITE, 31, 31, 31, 31, 15, 15, 8'hff, 1, 15));
        pending_items.push_back(make_item(FUNC_WRITE, 1, 8, 1, 2, 0, 0, 8'h0f, 0, 0));
        pending_items.push_back(make_item(FUNC_WRITE, 1, 8, 1, 2, 0, 1, 8'hf0, 0, 0));
        pending_items.push_back(make_item(FUNC_MERGE, 3, 2, 16, 16, 13, 14, 8'hff, 0, 0));
        pending_items.push_back(make_item(FUNC_READ,  0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_READ,  0, 0, 0, 0, 0, 0, 0, 1, 0));
        pending_items.push_back(make_item(FUNC_READ,  0, 0, 0, 0, 0, 0, 0, 1, 15));
        pending_items.push_back(make_item(FUNC_CLEAR, 31, 31, 31, 31, 15, 15, 8'hff, 1, 15));
        pending_items.push_back(make_item(FUNC_READ,  0, 0, 0, 0, 0, 0, 0, 1, 15));
        pending_items.push_back(make_item(FUNC_MERGE, 16, 16, 1, 1, 0, 0, 8'hff, 0, 0));
        pending_items.push_back(make_item(FUNC_READ,  0, 0, 0, 0, 0, 0, 0, 1, 15));
        wait_until_drained();

        // Random phases; the sender pauses between them until all results are in.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 73 : (phase == 3) ? 28 : 0;
            recv_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 28 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_items.push_back(random_item());
            wait_until_drained();
        end

        // Long receiver hold while items keep coming, so the input side backs up.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = hold_request + 1;
        for (int n = 0; n < 60; n++)
            pending_items.push_back(random_item());
        wait_until_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
